### design/asd_pkg.sv
// ---------------------------------------------------------------------------
// asd_pkg: shared types and constants for the archive stream deframer
// Phase codes, byte classes, error codes, register indexes, config struct, queue request, decode function.
// ---------------------------------------------------------------------------
package asd_pkg;

	localparam int MAX_PATH_LENGTH = 8192;
	localparam int CHUNK_BYTES     = 65536;
	localparam int CHUNK_W         = $clog2(CHUNK_BYTES);

	typedef enum logic [2:0] {
		PH_MAGIC = 3'd0,
		PH_TYPE  = 3'd1,
		PH_LEN   = 3'd2,
		PH_PATH  = 3'd3,
		PH_SIZE  = 3'd4,
		PH_DATA  = 3'd5,
		PH_ERROR = 3'd6
	} phase_t;

	localparam logic [1:0] CLS_HEADER = 2'd0;
	localparam logic [1:0] CLS_PATH   = 2'd1;
	localparam logic [1:0] CLS_DATA   = 2'd2;
	localparam logic [1:0] CLS_REJECT = 2'd3;

	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_MAGIC     = 2'd1;
	localparam logic [1:0] ERR_PATH_LEN  = 2'd2;

	localparam logic [1:0] REG_KEY          = 2'd0;
	localparam logic [1:0] REG_PLAIN_MAGIC  = 2'd1;
	localparam logic [1:0] REG_SECURE_MAGIC = 2'd2;
	localparam logic [1:0] REG_DIR_CODE     = 2'd3;

	typedef struct packed {
		logic [31:0] key;
		logic [31:0] plain_magic;
		logic [31:0] secure_magic;
		logic [7:0]  directory_code;
	} cfg_t;

	// one classified byte, handed from front to back
	typedef struct packed {
		logic [1:0]  cls;
		logic [7:0]  data;
		logic        decode;
		logic [1:0]  key_idx;
		logic        fend;
		logic        isdir;
		logic        secure;
		logic [63:0] esize;
		logic [1:0]  error;
	} req_t;

	// rotate right by 3, then XOR with the selected key byte
	function automatic logic [7:0] asd_decode(input logic [7:0] b, input logic [31:0] key,
		input logic [1:0] idx);
		logic [7:0] r;
		logic [7:0] kb;
		r = {b[2:0], b[7:3]};
		case (idx)
			2'd0:    kb = key[7:0];
			2'd1:    kb = key[15:8];
			2'd2:    kb = key[23:16];
			default: kb = key[31:24];
		endcase
		return r ^ kb;
	endfunction

endpackage

### design/archive_stream_deframer_top.sv
// ---------------------------------------------------------------------------
// archive_stream_deframer_top: archive byte stream parser and descrambler
// Path: an accepted request is written into the 2-entry queue, then popped into the output register.
// Throughput: 1 byte per cycle when no stall holds the parser, queue or output stage.
// Reset: arst_n clears parser state to the magic phase and empties the pipeline.
// ---------------------------------------------------------------------------
module archive_stream_deframer_top import asd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration writes
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// input byte channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  archive_byte,
	// classified byte channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  byte_class,
	output logic [7:0]  plain_byte,
	output logic        field_end,
	output logic        entry_is_directory,
	output logic        secure_active,
	output logic [63:0] entry_size,
	output logic [1:0]  fault_code
);

	// Configuration registers. Written only while the stream is idle: the user must keep to this, as the
	// block does not enforce it, so the parser and decode stage can both read them directly.
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key            <= 32'd0;
			cfg_q.plain_magic    <= 32'd0;
			cfg_q.secure_magic   <= 32'd0;
			cfg_q.directory_code <= 8'd1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_KEY:          cfg_q.key            <= cfg_data;
				REG_PLAIN_MAGIC:  cfg_q.plain_magic    <= cfg_data;
				REG_SECURE_MAGIC: cfg_q.secure_magic   <= cfg_data;
				REG_DIR_CODE:     cfg_q.directory_code <= cfg_data[7:0];
				default:          cfg_q                <= cfg_q;
			endcase
		end
	end

	// Front: a request is accepted whenever the queue has room, regardless of
	// whether the output register is holding a result.
	logic q_not_full;
	logic q_not_empty;
	logic q_pop;
	logic accept;
	req_t front_req;
	req_t q_head;

	assign in_stall = !q_not_full;
	assign accept   = in_valid && q_not_full;

	asd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.accept       (accept),
		.archive_byte (archive_byte),
		.req          (front_req)
	);

	// Short queue between parser and back end; each side stalls on its own.
	asd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_req  (front_req),
		.pop       (q_pop),
		.not_full  (q_not_full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	// Back: descramble and register the result for the downstream side.
	asd_back u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.key                (cfg_q.key),
		.q_not_empty        (q_not_empty),
		.q_head             (q_head),
		.q_pop              (q_pop),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.byte_class         (byte_class),
		.plain_byte         (plain_byte),
		.field_end          (field_end),
		.entry_is_directory (entry_is_directory),
		.secure_active      (secure_active),
		.entry_size         (entry_size),
		.fault_code         (fault_code)
	);

endmodule

### design/asd_front.sv
// ---------------------------------------------------------------------------
// asd_front: stream parser
// Tracks magic, entry headers, path and data counts; emits one request per byte.
// ---------------------------------------------------------------------------
module asd_front import asd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       accept,
	input  logic [7:0] archive_byte,
	output req_t       req
);

	phase_t              phase_q, phase_d;
	logic [2:0]          cnt_q, cnt_d;
	logic [63:0]         acc_q, acc_d;
	logic [31:0]         path_rem_q, path_rem_d;
	logic [63:0]         data_rem_q, data_rem_d;
	logic [1:0]          pidx_q, pidx_d;
	logic [CHUNK_W-1:0]  chunk_q, chunk_d;
	logic [7:0]          type_q, type_d;
	logic                secure_q, secure_d;
	logic [1:0]          err_q, err_d;

	logic [31:0] word32;
	logic [31:0] len_word;
	logic [63:0] size_word;
	logic        type_is_dir;

	// last byte completes a 4-byte word in acc[63:32] or an 8-byte word
	assign word32      = {archive_byte, acc_q[63:40]};
	assign len_word    = secure_q ? (word32 ^ cfg.key) : word32;
	assign size_word   = secure_q ? ({archive_byte, acc_q[63:8]} ^ {cfg.key, cfg.key})
	                              : {archive_byte, acc_q[63:8]};
	assign type_is_dir = (type_q == cfg.directory_code);

	// next state
	always_comb begin
		phase_d    = phase_q;
		cnt_d      = cnt_q;
		acc_d      = acc_q;
		path_rem_d = path_rem_q;
		data_rem_d = data_rem_q;
		pidx_d     = pidx_q;
		chunk_d    = chunk_q;
		type_d     = type_q;
		secure_d   = secure_q;
		err_d      = err_q;
		if (accept) begin
			unique case (phase_q)
				PH_MAGIC: begin
					acc_d = {archive_byte, acc_q[63:8]};
					cnt_d = cnt_q + 3'd1;
					if (cnt_q == 3'd3) begin
						cnt_d = 3'd0;
						if (word32 == (cfg.secure_magic ^ cfg.key)) begin
							secure_d = 1'b1;
							phase_d  = PH_TYPE;
						end else if (word32 == cfg.plain_magic) begin
							secure_d = 1'b0;
							phase_d  = PH_TYPE;
						end else begin
							err_d   = ERR_MAGIC;
							phase_d = PH_ERROR;
						end
					end
				end
				PH_TYPE: begin
					type_d  = secure_q ? (archive_byte ^ cfg.key[7:0]) : archive_byte;
					cnt_d   = 3'd0;
					phase_d = PH_LEN;
				end
				PH_LEN: begin
					acc_d = {archive_byte, acc_q[63:8]};
					cnt_d = cnt_q + 3'd1;
					if (cnt_q == 3'd3) begin
						cnt_d = 3'd0;
						if (secure_q && (len_word == 32'd0 ||
						    len_word > 32'(MAX_PATH_LENGTH))) begin
							err_d   = ERR_PATH_LEN;
							phase_d = PH_ERROR;
						end else if (len_word == 32'd0) begin
							phase_d = type_is_dir ? PH_TYPE : PH_SIZE;
						end else begin
							path_rem_d = len_word;
							pidx_d     = 2'd0;
							phase_d    = PH_PATH;
						end
					end
				end
				PH_PATH: begin
					pidx_d     = pidx_q + 2'd1;
					path_rem_d = path_rem_q - 32'd1;
					if (path_rem_q == 32'd1) begin
						cnt_d   = 3'd0;
						phase_d = type_is_dir ? PH_TYPE : PH_SIZE;
					end
				end
				PH_SIZE: begin
					acc_d = {archive_byte, acc_q[63:8]};
					cnt_d = cnt_q + 3'd1;
					if (cnt_q == 3'd7) begin
						if (size_word == 64'd0) begin
							phase_d = PH_TYPE;
						end else begin
							data_rem_d = size_word;
							chunk_d    = '0;
							pidx_d     = 2'd0;
							phase_d    = PH_DATA;
						end
					end
				end
				PH_DATA: begin
					chunk_d = (chunk_q == CHUNK_W'(CHUNK_BYTES - 1)) ? '0
					                                                 : chunk_q + 1'b1;
					pidx_d     = chunk_q[1:0];
					data_rem_d = data_rem_q - 64'd1;
					if (data_rem_q == 64'd1)
						phase_d = PH_TYPE;
				end
				PH_ERROR: begin
					phase_d = PH_ERROR;
				end
				default: begin
					phase_d = PH_ERROR;
				end
			endcase
		end
	end

	// request for the byte being accepted
	always_comb begin
		req        = '0;
		req.secure = secure_d;
		req.error  = err_d;
		unique case (phase_q)
			PH_MAGIC: begin
				req.cls = CLS_HEADER;
			end
			PH_TYPE: begin
				req.cls   = CLS_HEADER;
				req.isdir = (type_d == cfg.directory_code);
			end
			PH_LEN: begin
				req.cls   = CLS_HEADER;
				req.isdir = type_is_dir;
			end
			PH_PATH: begin
				req.cls     = CLS_PATH;
				req.data    = archive_byte;
				req.decode  = secure_q;
				req.key_idx = pidx_q;
				req.fend    = (path_rem_q == 32'd1);
				req.isdir   = type_is_dir;
			end
			PH_SIZE: begin
				req.cls   = CLS_HEADER;
				req.isdir = type_is_dir;
				if (cnt_q == 3'd7) begin
					req.fend  = 1'b1;
					req.esize = size_word;
				end
			end
			PH_DATA: begin
				req.cls     = CLS_DATA;
				req.data    = archive_byte;
				req.decode  = secure_q;
				req.key_idx = chunk_q[1:0];
				req.fend    = (data_rem_q == 64'd1);
				req.isdir   = type_is_dir;
			end
			default: begin
				req.cls = CLS_REJECT;
			end
		endcase
		if (phase_d == PH_ERROR) begin
			req.cls     = CLS_REJECT;
			req.data    = 8'd0;
			req.decode  = 1'b0;
			req.fend    = 1'b0;
			req.esize   = 64'd0;
			req.isdir   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_MAGIC;
			cnt_q      <= 3'd0;
			acc_q      <= 64'd0;
			path_rem_q <= 32'd0;
			data_rem_q <= 64'd0;
			pidx_q     <= 2'd0;
			chunk_q    <= '0;
			type_q     <= 8'd0;
			secure_q   <= 1'b0;
			err_q      <= ERR_NONE;
		end else begin
			phase_q    <= phase_d;
			cnt_q      <= cnt_d;
			acc_q      <= acc_d;
			path_rem_q <= path_rem_d;
			data_rem_q <= data_rem_d;
			pidx_q     <= pidx_d;
			chunk_q    <= chunk_d;
			type_q     <= type_d;
			secure_q   <= secure_d;
			err_q      <= err_d;
		end
	end

endmodule

### design/asd_queue.sv
// ---------------------------------------------------------------------------
// asd_queue: two-entry request queue
// Decouples the parser from the decode/output side; push and pop may happen in the same cycle.
// ---------------------------------------------------------------------------
module asd_queue import asd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  req_t push_req,
	input  logic pop,
	output logic not_full,
	output logic not_empty,
	output req_t head
);

	req_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign not_full  = (count_q != 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### design/asd_back.sv
// ---------------------------------------------------------------------------
// asd_back: byte decode and output register
// Pops a request, descrambles path/data bytes, holds the result until taken.
// ---------------------------------------------------------------------------
module asd_back import asd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] key,
	input  logic        q_not_empty,
	input  req_t        q_head,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  byte_class,
	output logic [7:0]  plain_byte,
	output logic        field_end,
	output logic        entry_is_directory,
	output logic        secure_active,
	output logic [63:0] entry_size,
	output logic [1:0]  fault_code
);

	logic       valid_q;
	logic [7:0] plain;

	assign q_pop     = q_not_empty && (!valid_q || !out_stall);
	assign out_valid = valid_q;
	assign plain     = q_head.decode ? asd_decode(q_head.data, key, q_head.key_idx)
	                                 : q_head.data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (q_pop)
			valid_q <= 1'b1;
		else if (!out_stall)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			byte_class         <= q_head.cls;
			plain_byte         <= plain;
			field_end          <= q_head.fend;
			entry_is_directory <= q_head.isdir;
			secure_active      <= q_head.secure;
			entry_size         <= q_head.esize;
			fault_code         <= q_head.error;
		end
	end

endmodule
